// ===== design/wps_pkg.sv =====
// Shared types and constants for the WAV PCM16 stream parser.
package wps_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [4:0]  FmtCaptureBytes = 5'd16;
  localparam logic [15:0] PcmFormat       = 16'd1;
  localparam logic [15:0] PcmBits         = 16'd16;
  localparam logic [15:0] MaxChannels     = 16'd2;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNotRiff   = 3'd1;
  localparam logic [2:0] StNotWave   = 3'd2;
  localparam logic [2:0] StBadFormat = 3'd3;
  localparam logic [2:0] StTruncated = 3'd4;

  localparam logic KindSample = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic [2:0]         status;
    logic [1:0]         channels;
    logic [31:0]        sample_rate;
    logic [30:0]        sample_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [1:0] num;
    out_t       first;
    out_t       second;
  } push_t;

endpackage

// ===== design/wav_pcm16_stream_parser_core.sv =====
// Top level of the WAV PCM16 stream parser: byte parser and result queue.
//
//  channel  direction  payload         handshake
//  in       input      wps_pkg::in_t   in_valid_i / in_stall_o
//  out      output     wps_pkg::out_t  out_valid_o / out_stall_i
//
// One byte is taken per cycle while in_stall_o is low; its results enter the
// queue at the same edge and leave one per cycle while out_stall_i is low.
// The input stalls while the four-entry result queue has room for fewer than two.
// Reset clears the parse state and the queue; the parser then expects "RIFF".
module wav_pcm16_stream_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  wps_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output wps_pkg::out_t out_data_o,
  input  logic          out_stall_i
);

  logic           acc;
  logic           full;
  wps_pkg::push_t push;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  wps_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .in_i   (in_data_i),
    .push_o (push)
  );

  wps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== design/wps_parser.sv =====
// Byte-wise RIFF/WAVE parse state and result formation for one transfer.
module wps_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  wps_pkg::in_t  in_i,
  output wps_pkg::push_t push_o
);

  typedef enum logic [2:0] {
    PhRiffId  = 3'd0,
    PhRiffLen = 3'd1,
    PhWaveId  = 3'd2,
    PhChkId   = 3'd3,
    PhChkLen  = 3'd4,
    PhFmt     = 3'd5,
    PhData    = 3'd6,
    PhSkip    = 3'd7
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] id_q, id_d;
  logic [31:0] len_q, len_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [7:0]  low_q, low_d;
  logic [31:0] tot_q, tot_d;

  logic [31:0] cnt_inc;
  logic [2:0]  err;
  logic        smp_v;
  logic [15:0] smp;
  logic [2:0]  eof_st;
  wps_pkg::out_t r_smp, r_st;

  assign cnt_inc = cnt_q + 32'd1;

  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    id_d   = id_q;
    len_d  = len_q;
    fmt_d  = fmt_q;
    ch_d   = ch_q;
    rate_d = rate_q;
    bits_d = bits_q;
    low_d  = low_q;
    tot_d  = tot_q;
    err    = wps_pkg::StOk;
    smp_v  = 1'b0;
    smp    = {in_i.data_byte, low_q};
    case (ph_q)
      PhRiffId, PhWaveId, PhChkId: begin
        id_d  = {id_q[23:0], in_i.data_byte};
        cnt_d = cnt_inc;
        if (cnt_inc == 32'd4) begin
          cnt_d = '0;
          if (ph_q == PhRiffId) begin
            if (id_d != wps_pkg::TagRiff) err = wps_pkg::StNotRiff;
            else ph_d = PhRiffLen;
          end else if (ph_q == PhWaveId) begin
            if (id_d != wps_pkg::TagWave) err = wps_pkg::StNotWave;
            else ph_d = PhChkId;
          end else begin
            len_d = '0;
            ph_d  = PhChkLen;
          end
        end
      end
      PhRiffLen: begin
        cnt_d = cnt_inc;
        if (cnt_inc == 32'd4) begin
          cnt_d = '0;
          ph_d  = PhWaveId;
        end
      end
      PhChkLen: begin
        len_d = {in_i.data_byte, len_q[31:8]};
        cnt_d = cnt_inc;
        if (cnt_inc == 32'd4) begin
          cnt_d = '0;
          if (id_q == wps_pkg::TagFmt) begin
            ph_d = PhFmt;
          end else if (id_q == wps_pkg::TagData) begin
            if (fmt_q != wps_pkg::PcmFormat || ch_q == '0 || ch_q > wps_pkg::MaxChannels
                || bits_q != wps_pkg::PcmBits) begin
              err = wps_pkg::StBadFormat;
            end else begin
              tot_d = {1'b0, len_d[31:1]};
              ph_d  = PhData;
            end
          end else begin
            ph_d = PhSkip;
          end
          if (err == wps_pkg::StOk && len_d == '0) begin
            ph_d = PhChkId;
          end
        end
      end
      PhFmt, PhData, PhSkip: begin
        if (ph_q == PhFmt && cnt_q < {27'd0, wps_pkg::FmtCaptureBytes}) begin
          case (cnt_q[3:0])
            4'd0:    fmt_d[7:0]    = in_i.data_byte;
            4'd1:    fmt_d[15:8]   = in_i.data_byte;
            4'd2:    ch_d[7:0]     = in_i.data_byte;
            4'd3:    ch_d[15:8]    = in_i.data_byte;
            4'd4:    rate_d[7:0]   = in_i.data_byte;
            4'd5:    rate_d[15:8]  = in_i.data_byte;
            4'd6:    rate_d[23:16] = in_i.data_byte;
            4'd7:    rate_d[31:24] = in_i.data_byte;
            4'd14:   bits_d[7:0]   = in_i.data_byte;
            4'd15:   bits_d[15:8]  = in_i.data_byte;
            default: ;
          endcase
        end
        if (ph_q == PhData) begin
          if (cnt_q[0]) smp_v = 1'b1;
          else low_d = in_i.data_byte;
        end
        cnt_d = cnt_inc;
        if (cnt_inc == len_q) begin
          ph_d  = PhChkId;
          cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  assign eof_st = (ph_d == PhChkId && cnt_d == '0) ? wps_pkg::StOk : wps_pkg::StTruncated;

  always_comb begin
    r_smp.kind         = wps_pkg::KindSample;
    r_smp.sample       = smp;
    r_smp.status       = wps_pkg::StOk;
    r_smp.channels     = (ch_d <= wps_pkg::MaxChannels) ? ch_d[1:0] : 2'd0;
    r_smp.sample_rate  = rate_d;
    r_smp.sample_count = tot_d[30:0];
    r_smp.last         = 1'b0;
    r_st               = r_smp;
    r_st.kind          = wps_pkg::KindStatus;
    r_st.sample        = '0;
    r_st.last          = 1'b1;
    r_st.status        = (err != wps_pkg::StOk) ? err : eof_st;
    push_o.first       = r_smp;
    push_o.second      = r_st;
    push_o.num         = 2'd0;
    if (acc_i) begin
      if (err != wps_pkg::StOk) begin
        push_o.first = r_st;
        push_o.num   = 2'd1;
      end else if (in_i.end_of_file) begin
        if (smp_v) begin
          push_o.num = 2'd2;
        end else begin
          push_o.first = r_st;
          push_o.num   = 2'd1;
        end
      end else if (smp_v) begin
        push_o.first.last = 1'b1;
        push_o.num        = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhRiffId;
      cnt_q  <= '0;
      id_q   <= '0;
      len_q  <= '0;
      fmt_q  <= '0;
      ch_q   <= '0;
      rate_q <= '0;
      bits_q <= '0;
      low_q  <= '0;
      tot_q  <= '0;
    end else if (acc_i) begin
      if (err != wps_pkg::StOk || in_i.end_of_file) begin
        ph_q   <= PhRiffId;
        cnt_q  <= '0;
        id_q   <= '0;
        len_q  <= '0;
        fmt_q  <= '0;
        ch_q   <= '0;
        rate_q <= '0;
        bits_q <= '0;
        low_q  <= '0;
        tot_q  <= '0;
      end else begin
        ph_q   <= ph_d;
        cnt_q  <= cnt_d;
        id_q   <= id_d;
        len_q  <= len_d;
        fmt_q  <= fmt_d;
        ch_q   <= ch_d;
        rate_q <= rate_d;
        bits_q <= bits_d;
        low_q  <= low_d;
        tot_q  <= tot_d;
      end
    end
  end

  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && in_i.end_of_file |=> ph_q == PhRiffId && cnt_q == '0)
    else $error("parser did not restart after final byte");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && (in_i.end_of_file || err != wps_pkg::StOk) |-> push_o.num != 2'd0)
    else $error("final or error byte gave no status result");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PhData |-> cnt_q != len_q)
    else $error("data byte count overran chunk length");

endmodule

// ===== design/wps_queue.sv =====
// Result queue: up to two results in per transfer, one out per unstalled cycle.
module wps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wps_pkg::push_t push_i,
  output logic           full_o,
  output logic           out_valid_o,
  output wps_pkg::out_t  out_data_o,
  input  logic           out_stall_i
);

  wps_pkg::out_t               mem_q [wps_pkg::QDepth];
  logic [wps_pkg::QAw-1:0]     wr_q, rd_q;
  logic [wps_pkg::QAw:0]       cnt_q;
  logic                        pop;
  logic [wps_pkg::QAw-1:0]     wr_nx;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign full_o      = cnt_q > (wps_pkg::QAw + 1)'(wps_pkg::QDepth - 2);
  assign wr_nx       = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.num == 2'd2) mem_q[wr_nx] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.num[wps_pkg::QAw-1:0];
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (wps_pkg::QAw + 1)'(push_i.num) - (wps_pkg::QAw + 1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> !full_o)
    else $error("push into full result queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (wps_pkg::QAw + 1)'(wps_pkg::QDepth))
    else $error("result queue count out of range");

endmodule
